// ===== rtl/gcd_pkg.sv =====
`timescale 1ns / 1ps
package gcd_pkg;

    localparam int TRIG_FRACTION_BITS_DEF = 30;
    localparam int CORDIC_ITERATIONS_DEF  = 32;
    localparam int MAX_ITERATIONS         = 48;

    localparam int ANGLE_BITS = 56;
    localparam int LAT_W      = 28;
    localparam int LON_W      = 29;
    localparam int DIST_W     = 25;

    // magnitude of a coordinate difference and the radians-per-microdegree constant
    localparam int MAG_W   = 30;
    localparam int RPM_W   = 31;
    localparam int PROD_W  = MAG_W + RPM_W;
    localparam int THETA_W = ANGLE_BITS + 4;

    // square roots and the vectoring pass
    localparam int SQRT_STEPS = 32;
    localparam int RAD_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int VEC_W      = 35;
    localparam int Z_W        = ANGLE_BITS + 3;
    localparam int ZL_W       = 29;
    localparam int ZH_W       = Z_W - 1 - ZL_W;
    localparam int K_W        = 24;
    localparam int PP_W       = ZL_W + K_W;
    localparam int FULL_W     = PP_W + ZL_W + 1;

    localparam logic [K_W-1:0]    EARTH_DIAMETER_M = 24'd12742000;
    localparam logic [DIST_W-1:0] MAX_DISTANCE     = 25'd20015087;

    localparam longint unsigned MICRODEG_HALF_TURN = 64'd180000000;
    localparam longint unsigned PI_NUM_FRAC        = 64'd141592653589793238;
    localparam longint unsigned PI_DEN             = 64'd1000000000000000000;

    typedef longint atan_tab_t [MAX_ITERATIONS];

    // restoring division for table setup; den stays below 2^63
    function automatic longint unsigned udiv_calc(input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        int              i;
        q = 64'd0;
        r = 64'd0;
        for (i = 63; i >= 0; i--)
        begin
            r = {r[62:0], num[i]};
            if (r >= den)
            begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // pi in Q56 by long division, rounded
    function automatic longint unsigned pi_q_calc();
        longint unsigned q;
        longint unsigned r;
        int              i;
        q = 64'd3;
        r = PI_NUM_FRAC;
        for (i = 0; i < ANGLE_BITS; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= PI_DEN)
            begin
                r = r - PI_DEN;
                q = q | 64'd1;
            end
        end
        if (2 * r >= PI_DEN)
        begin
            q = q + 64'd1;
        end
        return q;
    endfunction

    localparam longint unsigned PI_Q      = pi_q_calc();
    localparam longint unsigned HALF_PI_Q = (PI_Q + 64'd1) >> 1;
    localparam longint unsigned RAD_PER_MICRODEG =
        (PI_Q + MICRODEG_HALF_TURN / 2) / MICRODEG_HALF_TURN;

    // arctan(2^-i) in Q56: pi/4 for i = 0, the truncated series otherwise
    function automatic atan_tab_t atan_tab_calc();
        atan_tab_t       tab;
        longint          sum;
        longint          t;
        longint unsigned p;
        int              i;
        int              n;
        for (i = 0; i < MAX_ITERATIONS; i++)
        begin
            if (i == 0)
            begin
                tab[i] = longint'((PI_Q + 64'd2) >> 2);
            end
            else
            begin
                sum = 0;
                p   = 64'd1 << (ANGLE_BITS - i);
                for (n = 0; n < 64; n++)
                begin
                    if (p != 64'd0)
                    begin
                        t   = longint'(udiv_calc(p, 64'(2 * n + 1)));
                        sum = n[0] ? sum - t : sum + t;
                        p   = (2 * i >= ANGLE_BITS) ? 64'd0 : p >> (2 * i);
                    end
                end
                tab[i] = sum;
            end
        end
        return tab;
    endfunction

    // 1/G^2 of an n_it step CORDIC in Q(f)
    function automatic longint unsigned inv_gain_sq_calc(input int f, input int n_it);
        longint unsigned k2;
        int              i;
        k2 = 64'd1 << 62;
        for (i = 0; i < 64; i++)
        begin
            if (i < n_it && 2 * i < 63)
            begin
                k2 = k2 - udiv_calc(k2, (64'd1 << (2 * i)) + 64'd1);
            end
        end
        return (k2 + (64'd1 << (61 - f))) >> (62 - f);
    endfunction

endpackage

// ===== rtl/gcd_pair_if.sv =====
`timescale 1ns / 1ps
interface gcd_pair_if;
    import gcd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] first_latitude;
    logic signed [LON_W-1:0] first_longitude;
    logic signed [LAT_W-1:0] second_latitude;
    logic signed [LON_W-1:0] second_longitude;

    modport source (
        output valid, first_latitude, first_longitude, second_latitude, second_longitude,
        input  ready
    );

    modport sink (
        input  valid, first_latitude, first_longitude, second_latitude, second_longitude,
        output ready
    );

endinterface

// ===== rtl/gcd_dist_if.sv =====
`timescale 1ns / 1ps
interface gcd_dist_if;
    import gcd_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance_metres;

    modport source (
        output valid, distance_metres,
        input  ready
    );

    modport sink (
        input  valid, distance_metres,
        output ready
    );

endinterface

// ===== rtl/great_circle_distance_core.sv =====
`timescale 1ns / 1ps
// Haversine distance between two points given in signed microdegrees.
// points:   one transfer per point pair (both latitudes and longitudes).
// distance: one transfer per pair, great-circle distance in metres on a
//           6371 km sphere, rounded, saturated at half the circumference.
// Results leave in the order the pairs came in.
// The pipeline has 2*CORDIC_ITERATIONS + 46 stages: the two CORDIC chains
// (one iteration per stage), the 32 stage digit-by-digit square root and
// fourteen stages for input registers, range reduction, multiplies and
// scaling.
// Throughput: one pair per cycle, sustained, while the receiver takes results.
// A stall of the receiver freezes the whole pipeline; points.ready drops in
// the same cycle and nothing is lost or repeated. The output register is the
// last pipeline stage, so a new pair is taken whenever that result moves.
// Reset empties the pipeline (all valid bits clear); no clearing pass.
module great_circle_distance_core #(
    parameter int TRIG_FRACTION_BITS = gcd_pkg::TRIG_FRACTION_BITS_DEF,
    parameter int CORDIC_ITERATIONS  = gcd_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    gcd_pair_if.sink  points,
    gcd_dist_if.source distance
);
    import gcd_pkg::*;

    localparam int F      = TRIG_FRACTION_BITS;
    localparam int N      = CORDIC_ITERATIONS;
    localparam int XY_W   = F + 3;
    localparam int ABS_W  = F + 1;
    localparam int SQ_W   = F + 2;
    localparam int SUM_W  = F + 3;
    localparam int P1_W   = 2 * ABS_W + 1;
    localparam int P2_W   = SQ_W + F + 1;
    localparam int P3_W   = 2 * ABS_W + 1;

    localparam int NUM_LANES = 4;
    localparam int LANE_DLAT = 0;
    localparam int LANE_DLON = 1;
    localparam int LANE_LAT1 = 2;
    localparam int LANE_LAT2 = 3;

    localparam int S_M0    = 5 + N;
    localparam int S_A     = S_M0 + 4;
    localparam int S_SQ0   = S_A + 1;
    localparam int S_VEC0  = S_SQ0 + SQRT_STEPS;
    localparam int DEPTH   = S_VEC0 + N + 4;

    localparam atan_tab_t ATAN = atan_tab_calc();
    localparam logic [F-1:0]     INV_GAIN_SQ = F'(inv_gain_sq_calc(F, N));
    localparam logic [RPM_W-1:0] RPM_C       = RPM_W'(RAD_PER_MICRODEG);
    localparam logic signed [THETA_W-1:0] PI_S      = THETA_W'(PI_Q);
    localparam logic signed [THETA_W-1:0] HALF_PI_S = THETA_W'(HALF_PI_Q);
    localparam logic signed [XY_W-1:0]    ONE_XY    = XY_W'(1) <<< F;
    localparam logic [ABS_W-1:0]          ONE_A     = ABS_W'(1) << F;
    localparam logic [P1_W-1:0] RND1 = P1_W'(1) << (F - 1);
    localparam logic [P2_W-1:0] RND2 = P2_W'(1) << (F - 1);
    localparam logic [P3_W-1:0] RND3 = P3_W'(1) << (F - 1);
    localparam logic [FULL_W-1:0] RND_D = FULL_W'(1) << (ANGLE_BITS - 1);

    // ---------------------------------------------------------------- control
    logic             adv;
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;

    assign adv            = !vld_reg[DEPTH-1] || distance.ready;
    assign points.ready   = adv;
    assign distance.valid = vld_reg[DEPTH-1];
    assign vld_next       = {vld_reg[DEPTH-2:0], points.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // ---------------------------------------------------------------- front end
    logic signed [LAT_W-1:0] lat1_reg, lat2_reg;
    logic signed [LON_W-1:0] lon1_reg, lon2_reg;

    logic signed [MAG_W:0]      ang_s    [NUM_LANES];
    logic [MAG_W-1:0]           mag_next [NUM_LANES];
    logic [MAG_W-1:0]           mag_reg  [NUM_LANES];
    logic                       neg_reg  [NUM_LANES];
    logic [PROD_W-1:0]          prod_reg [NUM_LANES];
    logic                       pneg_reg [NUM_LANES];
    logic [PROD_W-1:0]          ph       [NUM_LANES];
    logic signed [THETA_W-1:0]  th_next  [NUM_LANES];
    logic signed [THETA_W-1:0]  th_reg   [NUM_LANES];

    always_comb
    begin
        ang_s[LANE_DLAT] = (MAG_W + 1)'(lat2_reg) - (MAG_W + 1)'(lat1_reg);
        ang_s[LANE_DLON] = (MAG_W + 1)'(lon2_reg) - (MAG_W + 1)'(lon1_reg);
        ang_s[LANE_LAT1] = (MAG_W + 1)'(lat1_reg);
        ang_s[LANE_LAT2] = (MAG_W + 1)'(lat2_reg);
        for (int l = 0; l < NUM_LANES; l++)
        begin
            mag_next[l] = MAG_W'(ang_s[l] < 0 ? -ang_s[l] : ang_s[l]);
            // difference lanes take the half angle, rounded up on the magnitude
            if (l == LANE_DLAT || l == LANE_DLON)
            begin
                ph[l] = (prod_reg[l] + PROD_W'(1)) >> 1;
            end
            else
            begin
                ph[l] = prod_reg[l];
            end
            th_next[l] = pneg_reg[l] ? -THETA_W'(ph[l]) : THETA_W'(ph[l]);
        end
    end

    // ---------------------------------------------------------------- rotation CORDIC
    // index 0 holds the range-reduced angle, index k+1 the result of step k
    logic signed [XY_W-1:0]    rx_reg [N+1][NUM_LANES];
    logic signed [XY_W-1:0]    ry_reg [N+1][NUM_LANES];
    logic signed [THETA_W-1:0] rt_reg [N+1][NUM_LANES];
    logic                      rf_reg [N+1][NUM_LANES];
    logic signed [XY_W-1:0]    rx_next [N][NUM_LANES];
    logic signed [XY_W-1:0]    ry_next [N][NUM_LANES];
    logic signed [THETA_W-1:0] rt_next [N][NUM_LANES];

    always_comb
    begin
        logic signed [THETA_W-1:0] at_c;
        for (int k = 0; k < N; k++)
        begin
            at_c = THETA_W'(ATAN[k]);
            for (int l = 0; l < NUM_LANES; l++)
            begin
                if (rt_reg[k][l] >= 0)
                begin
                    rx_next[k][l] = rx_reg[k][l] - (ry_reg[k][l] >>> k);
                    ry_next[k][l] = ry_reg[k][l] + (rx_reg[k][l] >>> k);
                    rt_next[k][l] = rt_reg[k][l] - at_c;
                end
                else
                begin
                    rx_next[k][l] = rx_reg[k][l] + (ry_reg[k][l] >>> k);
                    ry_next[k][l] = ry_reg[k][l] - (rx_reg[k][l] >>> k);
                    rt_next[k][l] = rt_reg[k][l] + at_c;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lat1_reg <= points.first_latitude;
            lon1_reg <= points.first_longitude;
            lat2_reg <= points.second_latitude;
            lon2_reg <= points.second_longitude;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                mag_reg[l]  <= mag_next[l];
                neg_reg[l]  <= ang_s[l] < 0;
                prod_reg[l] <= PROD_W'(mag_reg[l]) * PROD_W'(RPM_C);
                pneg_reg[l] <= neg_reg[l];
                th_reg[l]   <= th_next[l];
                // one turn of pi at most brings any input into [-pi/2, pi/2]
                rx_reg[0][l] <= ONE_XY;
                ry_reg[0][l] <= '0;
                if (th_reg[l] > HALF_PI_S)
                begin
                    rt_reg[0][l] <= th_reg[l] - PI_S;
                    rf_reg[0][l] <= 1'b1;
                end
                else if (th_reg[l] < -HALF_PI_S)
                begin
                    rt_reg[0][l] <= th_reg[l] + PI_S;
                    rf_reg[0][l] <= 1'b1;
                end
                else
                begin
                    rt_reg[0][l] <= th_reg[l];
                    rf_reg[0][l] <= 1'b0;
                end
                for (int k = 0; k < N; k++)
                begin
                    rx_reg[k+1][l] <= rx_next[k][l];
                    ry_reg[k+1][l] <= ry_next[k][l];
                    rt_reg[k+1][l] <= rt_next[k][l];
                    rf_reg[k+1][l] <= rf_reg[k][l];
                end
            end
        end
    end

    // ---------------------------------------------------------------- haversine term
    logic signed [XY_W-1:0] sa_v, sb_v, c1_v, c2_v;
    logic                   c1_neg, c2_neg;
    logic [ABS_W-1:0] m0_sa_reg, m0_sb_reg, m0_c1_reg, m0_c2_reg;
    logic             m0_ds_reg, m1_ds_reg, m2_ds_reg, m3_ds_reg;
    logic [P1_W-1:0]  p_sa, p_sb, p_cc;
    logic [SQ_W-1:0]  m1_sa_reg, m1_sb_reg, m1_cc_reg;
    logic [P2_W-1:0]  p_t1, p_s2, p_c;
    logic [ABS_W-1:0] m2_t1_reg, m2_s2_reg, m2_cc_reg;
    logic [P3_W-1:0]  p_t2;
    logic [ABS_W-1:0] m3_t1_reg, m3_t2_reg;
    logic signed [SUM_W-1:0] a_sum;
    logic [ABS_W-1:0] a_next, a_reg;

    always_comb
    begin
        sa_v   = ry_reg[N][LANE_DLAT];
        sb_v   = ry_reg[N][LANE_DLON];
        c1_v   = rx_reg[N][LANE_LAT1];
        c2_v   = rx_reg[N][LANE_LAT2];
        c1_neg = (c1_v != '0) && (c1_v[XY_W-1] ^ rf_reg[N][LANE_LAT1]);
        c2_neg = (c2_v != '0) && (c2_v[XY_W-1] ^ rf_reg[N][LANE_LAT2]);

        p_sa = (P1_W'(m0_sa_reg) * P1_W'(m0_sa_reg) + RND1) >> F;
        p_sb = (P1_W'(m0_sb_reg) * P1_W'(m0_sb_reg) + RND1) >> F;
        p_cc = (P1_W'(m0_c1_reg) * P1_W'(m0_c2_reg) + RND1) >> F;
        p_t1 = (P2_W'(m1_sa_reg) * P2_W'(INV_GAIN_SQ) + RND2) >> F;
        p_s2 = (P2_W'(m1_sb_reg) * P2_W'(INV_GAIN_SQ) + RND2) >> F;
        p_c  = (P2_W'(m1_cc_reg) * P2_W'(INV_GAIN_SQ) + RND2) >> F;
        p_t2 = (P3_W'(m2_cc_reg) * P3_W'(m2_s2_reg) + RND3) >> F;

        // cosines of opposite sign subtract the second term
        if (m3_ds_reg)
        begin
            a_sum = SUM_W'(m3_t1_reg) - SUM_W'(m3_t2_reg);
        end
        else
        begin
            a_sum = SUM_W'(m3_t1_reg) + SUM_W'(m3_t2_reg);
        end
        if (a_sum < 0)
        begin
            a_next = '0;
        end
        else if (a_sum > SUM_W'(ONE_A))
        begin
            a_next = ONE_A;
        end
        else
        begin
            a_next = ABS_W'(a_sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m0_sa_reg <= ABS_W'(sa_v < 0 ? -sa_v : sa_v);
            m0_sb_reg <= ABS_W'(sb_v < 0 ? -sb_v : sb_v);
            m0_c1_reg <= ABS_W'(c1_v < 0 ? -c1_v : c1_v);
            m0_c2_reg <= ABS_W'(c2_v < 0 ? -c2_v : c2_v);
            m0_ds_reg <= c1_neg != c2_neg;
            m1_sa_reg <= SQ_W'(p_sa);
            m1_sb_reg <= SQ_W'(p_sb);
            m1_cc_reg <= SQ_W'(p_cc);
            m1_ds_reg <= m0_ds_reg;
            m2_t1_reg <= ABS_W'(p_t1);
            m2_s2_reg <= ABS_W'(p_s2);
            m2_cc_reg <= ABS_W'(p_c);
            m2_ds_reg <= m1_ds_reg;
            m3_t1_reg <= m2_t1_reg;
            m3_t2_reg <= ABS_W'(p_t2);
            m3_ds_reg <= m2_ds_reg;
            a_reg     <= a_next;
        end
    end

    // ---------------------------------------------------------------- square roots
    // lane 0: sqrt(a), lane 1: sqrt(1 - a); one result bit per stage
    logic [RAD_W-1:0] sv_reg  [SQRT_STEPS][2];
    logic [RAD_W-1:0] sr_reg  [SQRT_STEPS][2];
    logic [RAD_W-1:0] sv_next [SQRT_STEPS][2];
    logic [RAD_W-1:0] sr_next [SQRT_STEPS][2];

    always_comb
    begin
        logic [RAD_W-1:0] bit_c;
        logic [RAD_W-1:0] trial;
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            bit_c = RAD_W'(1) << (2 * (SQRT_STEPS - 1 - k));
            for (int j = 0; j < 2; j++)
            begin
                trial = sr_reg[k][j] + bit_c;
                if (sv_reg[k][j] >= trial)
                begin
                    sv_next[k][j] = sv_reg[k][j] - trial;
                    sr_next[k][j] = (sr_reg[k][j] >> 1) + bit_c;
                end
                else
                begin
                    sv_next[k][j] = sv_reg[k][j];
                    sr_next[k][j] = sr_reg[k][j] >> 1;
                end
            end
        end
    end

    // ---------------------------------------------------------------- vectoring CORDIC
    logic signed [VEC_W-1:0] vx_reg  [N+1];
    logic signed [VEC_W-1:0] vy_reg  [N+1];
    logic signed [Z_W-1:0]   vz_reg  [N+1];
    logic signed [VEC_W-1:0] vx_next [N];
    logic signed [VEC_W-1:0] vy_next [N];
    logic signed [Z_W-1:0]   vz_next [N];

    always_comb
    begin
        logic signed [Z_W-1:0] at_v;
        for (int k = 0; k < N; k++)
        begin
            at_v = Z_W'(ATAN[k]);
            if (vy_reg[k] >= 0)
            begin
                vx_next[k] = vx_reg[k] + (vy_reg[k] >>> k);
                vy_next[k] = vy_reg[k] - (vx_reg[k] >>> k);
                vz_next[k] = vz_reg[k] + at_v;
            end
            else
            begin
                vx_next[k] = vx_reg[k] - (vy_reg[k] >>> k);
                vy_next[k] = vy_reg[k] + (vx_reg[k] >>> k);
                vz_next[k] = vz_reg[k] - at_v;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sv_reg[0][0] <= RAD_W'(a_reg) << (62 - F);
            sv_reg[0][1] <= RAD_W'(ONE_A - a_reg) << (62 - F);
            sr_reg[0][0] <= '0;
            sr_reg[0][1] <= '0;
            for (int k = 0; k < SQRT_STEPS - 1; k++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    sv_reg[k+1][j] <= sv_next[k][j];
                    sr_reg[k+1][j] <= sr_next[k][j];
                end
            end
            vx_reg[0] <= VEC_W'(sr_next[SQRT_STEPS-1][1][ROOT_W-1:0]);
            vy_reg[0] <= VEC_W'(sr_next[SQRT_STEPS-1][0][ROOT_W-1:0]);
            vz_reg[0] <= '0;
            for (int k = 0; k < N; k++)
            begin
                vx_reg[k+1] <= vx_next[k];
                vy_reg[k+1] <= vy_next[k];
                vz_reg[k+1] <= vz_next[k];
            end
        end
    end

    // ---------------------------------------------------------------- scale to metres
    // z * 2r / 2^56, split into two 29 x 24 partial products
    logic [Z_W-2:0]      zc;
    logic [ZL_W-1:0]     dz_lo_reg;
    logic [ZH_W-1:0]     dz_hi_reg;
    logic [PP_W-1:0]     pl_reg, ph_reg;
    logic [FULL_W-1:0]   full;
    logic [FULL_W-ANGLE_BITS-1:0] dist_raw;
    logic [DIST_W-1:0]   dist_reg;

    always_comb
    begin
        zc       = (vz_reg[N] < 0) ? '0 : (Z_W - 1)'(vz_reg[N]);
        full     = (FULL_W'(ph_reg) << ZL_W) + FULL_W'(pl_reg) + RND_D;
        dist_raw = full[FULL_W-1:ANGLE_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dz_lo_reg <= zc[ZL_W-1:0];
            dz_hi_reg <= zc[Z_W-2:ZL_W];
            pl_reg    <= PP_W'(dz_lo_reg) * PP_W'(EARTH_DIAMETER_M);
            ph_reg    <= PP_W'(dz_hi_reg) * PP_W'(EARTH_DIAMETER_M);
            if (dist_raw > (FULL_W - ANGLE_BITS)'(MAX_DISTANCE))
            begin
                dist_reg <= MAX_DISTANCE;
            end
            else
            begin
                dist_reg <= DIST_W'(dist_raw);
            end
        end
    end

    assign distance.distance_metres = dist_reg;

    // ---------------------------------------------------------------- checks
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        points.valid && points.ready |=> vld_reg[0])
        else $error("accepted pair did not enter the pipeline");

    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        distance.valid |-> distance.distance_metres <= MAX_DISTANCE)
        else $error("distance above half circumference");

    a_roots_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S_VEC0] |-> (72'(vx_reg[0]) * 72'(vx_reg[0]) + 72'(vy_reg[0]) * 72'(vy_reg[0]))
            <= (72'(1) << 62))
        else $error("square roots exceed the unit circle");

endmodule
